@@ sv/gmps_pkg.sv @@
// Shared constants, types and helpers for the grid minimum path sum block.
// No dependencies; imported by the row memory, result queue and top level.
package gmps_pkg;

	localparam int WEIGHT_W        = 16;
	localparam int SUM_W           = 24;
	localparam int CFG_W           = 8;
	localparam int MAX_SIZE_DEF    = 128;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int GRID_SIZE_RESET = 80;
	localparam int OUT_DEPTH       = 4;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Position flags of the cell in the compute stage
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last;
	} s1_ctrl_t;

	// Add a weight to a sum, saturating at the all-ones sum
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [WEIGHT_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

endpackage

@@ sv/gmps_row_mem.sv @@
// One-row buffer of best path sums, a synchronous memory with registered read.
// Depends on gmps_pkg for the sum width.
module gmps_row_mem #(
	parameter int DEPTH  = gmps_pkg::MAX_SIZE_DEF,
	parameter int ADDR_W = $clog2(gmps_pkg::MAX_SIZE_DEF)
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [gmps_pkg::SUM_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [gmps_pkg::SUM_W-1:0] wr_data
);
	import gmps_pkg::*;

	logic [SUM_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/gmps_out_fifo.sv @@
// Small result queue between the compute stage and the output channel.
// Depends on gmps_pkg for the sum width and queue depth.
module gmps_out_fifo #(
	parameter int DEPTH = gmps_pkg::OUT_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [gmps_pkg::SUM_W-1:0]  push_data,
	input  logic                        pop,
	output logic                        head_valid,
	output logic [gmps_pkg::SUM_W-1:0]  head_data,
	output logic [$clog2(DEPTH+1)-1:0]  count
);
	import gmps_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [SUM_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = count_q;

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

@@ sv/grid_min_path_sum_top.sv @@
// Grid minimum right/down path sum: top level with index control and compute stage.
// Depends on gmps_pkg, gmps_row_mem and gmps_out_fifo.
//
// Usage:
//   Cells of a square grid enter in row-major order on cell_weight, one item
//   per cycle, accepted when in_valid is high and in_stall is low. After the
//   last cell of a grid one item leaves on path_sum, taken when out_valid is
//   high and out_stall is low. The block then starts the next grid.
//   grid_size is written through cfg_valid/cfg_ready while the block is idle;
//   a write restarts the grid in progress. cfg_ready is always high.
// Throughput and result path:
//   One cell per cycle while in_stall is low. The result of a grid is offered once
//   its last cell has passed the compute stage: the row buffer read completes at the
//   accepting edge, then add/compare, write back and the queue push follow, and the
//   queue registers it. A row buffer entry is written before the row below reads it.
// Stall:
//   Results wait in a four-entry queue; in_stall rises when queued results plus a
//   pending push reach four, so cells keep flowing while out_stall holds a result.
// Reset:
//   Clears indices, the left sum and the queue; grid size returns to 80. No clearing pass.
module grid_min_path_sum_top #(
	parameter int MAX_SIZE    = gmps_pkg::MAX_SIZE_DEF,
	parameter int WEIGHT_BITS = gmps_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gmps_pkg::WEIGHT_W-1:0] cell_weight,
	input  logic                          in_valid,
	output logic                          in_stall,
	output logic [gmps_pkg::SUM_W-1:0]    path_sum,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic [gmps_pkg::CFG_W-1:0]    grid_size,
	input  logic                          cfg_valid,
	output logic                          cfg_ready
);
	import gmps_pkg::*;

	localparam int IDX_W   = $clog2(MAX_SIZE);
	localparam int SZ_W    = ($clog2(MAX_SIZE+1) > CFG_W) ? $clog2(MAX_SIZE+1) : CFG_W;
	localparam int N_RESET = (GRID_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : GRID_SIZE_RESET;
	localparam int QCNT_W  = $clog2(OUT_DEPTH+1);
	localparam logic [WEIGHT_W-1:0] W_MASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}}
		: WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

	logic             cfg_fire;
	logic             in_fire;
	logic [IDX_W-1:0] last_idx_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [SZ_W-1:0]  cfg_ext;
	logic [SZ_W-1:0]  n_new;
	logic [IDX_W-1:0] row_cur;
	logic [IDX_W-1:0] col_cur;
	logic             col_end;
	logic             row_end;

	logic                valid_s1;
	logic [WEIGHT_W-1:0] w_s1;
	s1_ctrl_t            ctrl_s1;
	logic [IDX_W-1:0]    col_s1;
	logic [SUM_W-1:0]    left_q;
	logic [SUM_W-1:0]    up_sum;
	logic [SUM_W-1:0]    base_sum;
	logic [SUM_W-1:0]    best;

	logic              q_push;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0]   q_need;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && !in_stall;

	// Clamp the written size to 1..MAX_SIZE
	always_comb begin
		cfg_ext = SZ_W'(grid_size);
		if (cfg_ext == '0) begin
			n_new = SZ_W'(1);
		end else if (cfg_ext > SZ_W'(MAX_SIZE)) begin
			n_new = SZ_W'(MAX_SIZE);
		end else begin
			n_new = cfg_ext;
		end
	end

	// Current position, restarting if it lies outside the grid
	always_comb begin
		if (row_q > last_idx_q || col_q > last_idx_q) begin
			row_cur = '0;
			col_cur = '0;
		end else begin
			row_cur = row_q;
			col_cur = col_q;
		end
		col_end = (col_cur == last_idx_q);
		row_end = (row_cur == last_idx_q);
	end

	// Hold grid size, advance row and column indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= IDX_W'(N_RESET - 1);
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_fire) begin
			last_idx_q <= IDX_W'(n_new - SZ_W'(1));
			row_q      <= '0;
			col_q      <= '0;
		end else if (in_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	// Compute stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	// Compute stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_s1              <= cell_weight & W_MASK;
			col_s1            <= col_cur;
			ctrl_s1.first_row <= (row_cur == '0);
			ctrl_s1.first_col <= (col_cur == '0);
			ctrl_s1.last      <= col_end && row_end;
		end
	end

	gmps_row_mem #(
		.DEPTH  (MAX_SIZE),
		.ADDR_W (IDX_W)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_cur),
		.rd_data (up_sum),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (best)
	);

	// Pick the smaller predecessor among the cells that exist
	always_comb begin
		priority if (ctrl_s1.first_row && ctrl_s1.first_col) begin
			base_sum = '0;
		end else if (ctrl_s1.first_row) begin
			base_sum = left_q;
		end else if (ctrl_s1.first_col) begin
			base_sum = up_sum;
		end else begin
			base_sum = (up_sum < left_q) ? up_sum : left_q;
		end
		best = sat_add(base_sum, w_s1);
	end

	// Hold the best sum of the cell to the left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (valid_s1) begin
			left_q <= best;
		end
	end

	assign q_push = valid_s1 && ctrl_s1.last;
	assign q_pop  = out_valid && !out_stall;

	gmps_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (best),
		.pop        (q_pop),
		.head_valid (out_valid),
		.head_data  (path_sum),
		.count      (q_count)
	);

	// Stall when a new item could find the result queue full
	assign q_need   = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(q_push);
	assign in_stall = (q_need >= (QCNT_W+1)'(OUT_DEPTH));

`ifndef NO_ASSERTIONS
	a_idx_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_idx_q && col_q <= last_idx_q)
		else $error("grid position outside the grid");

	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctrl_s1.last |=> out_valid)
		else $error("finished grid result not offered");

	a_first_col_addr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ctrl_s1.first_col |-> col_s1 != '0)
		else $error("column flag disagrees with row buffer address");
`endif

endmodule

@@ verif/tb_grid_min_path_sum_top.sv @@
// Testbench for grid_min_path_sum_top: streams grid cells, predicts each path sum
// with its own row dynamic program or takes it from the directed table, and checks every result item in order.
// Depends on gmps_pkg and the grid_min_path_sum_top RTL.
`timescale 1ns / 1ps

module tb_grid_min_path_sum_top;
	import gmps_pkg::*;

	localparam int DIR_N       = 24;
	localparam int RAND_ITEMS  = 380;
	localparam int RESET_CELLS = GRID_SIZE_RESET + 10;
	localparam int BIG_CELLS   = MAX_SIZE_DEF + 8;
	localparam int SETTLE_CYC  = 6;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_W'((64'd1 << WEIGHT_BITS_DEF) - 1);

	typedef struct {
		bit                  new_size;
		logic [CFG_W-1:0]    size;
		logic [WEIGHT_W-1:0] weight;
		bit                  has_sum;
		logic [SUM_W-1:0]    sum;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic [WEIGHT_W-1:0] cell_weight = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SUM_W-1:0]    path_sum;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CFG_W-1:0]    grid_size = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;

	// Predictor state: best sums of the row above, the cell to the left, position
	logic [SUM_W-1:0]    best_above [MAX_SIZE_DEF];
	logic [SUM_W-1:0]    best_left;
	int unsigned         cur_row;
	int unsigned         cur_col;
	logic [CFG_W-1:0]    size_reg;

	logic [SUM_W-1:0]    expected_sums [$];
	logic [SUM_W-1:0]    want_sum;
	int unsigned         errors;
	dir_row_t            dir_table [DIR_N];

	// Pacing of both sides
	bit                  gaps_on;
	bit                  stall_on;
	int unsigned         burst_left;
	int unsigned         stall_left;

	grid_min_path_sum_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_weight(cell_weight),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.path_sum   (path_sum),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grid_size  (grid_size),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Advance the path-sum model by one cell; flag the grid's last cell
	task automatic accumulate_cell(input logic [WEIGHT_W-1:0] w, output bit done,
			output logic [SUM_W-1:0] sum);
		int unsigned n;
		int unsigned r;
		int unsigned c;
		logic [SUM_W-1:0] base;
		logic [SUM_W:0] total;
		n = size_reg;
		if (n == 0) n = 1;
		if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
		r = cur_row;
		c = cur_col;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		if (r == 0 && c == 0) base = '0;
		else if (r == 0) base = best_left;
		else if (c == 0) base = best_above[c];
		else base = (best_above[c] < best_left) ? best_above[c] : best_left;
		total = {1'b0, base} + (SUM_W+1)'(w & WEIGHT_MASK);
		sum = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
		best_above[c] = sum;
		best_left = sum;
		done = 1'b0;
		if (c + 1 < n) begin
			cur_row = r;
			cur_col = c + 1;
		end else begin
			cur_col = 0;
			if (r + 1 < n) begin
				cur_row = r + 1;
			end else begin
				cur_row = 0;
				done = 1'b1;
			end
		end
	endtask

	// Offer one cell and hold it until accepted; queue the sum it completes
	task automatic push_cell(input logic [WEIGHT_W-1:0] w, input bit use_typed,
			input logic [SUM_W-1:0] typed_sum);
		bit done;
		logic [SUM_W-1:0] sum;
		cell_weight <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		accumulate_cell(w, done, sum);
		if (done) expected_sums.push_back(use_typed ? typed_sum : sum);
	endtask

	// Drop valid for a random gap at the end of each burst
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = gaps_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 31);
		end
	endtask

	task automatic send_cell(input logic [WEIGHT_W-1:0] w);
		push_cell(w, 1'b0, '0);
		pace();
	endtask

	// Wait until every result is out and the pipeline has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write grid_size; the grid in progress restarts
	task automatic write_size(input logic [CFG_W-1:0] v);
		grid_size <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		size_reg = v;
		cur_row = 0;
		cur_col = 0;
	endtask

	function automatic logic [WEIGHT_W-1:0] rand_weight(input int unsigned mode);
		logic [WEIGHT_W-1:0] w;
		unique case (mode)
			0: w = WEIGHT_W'($urandom_range(0, 15));
			1: w = ($urandom_range(0, 1) != 0) ? '1 : '0;
			2: w = '1 - WEIGHT_W'($urandom_range(0, 255));
			default: w = WEIGHT_W'($urandom);
		endcase
		return w;
	endfunction

	// Receiver: alternate stall runs and free runs while stalling is enabled
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			out_stall <= stall_on && !out_stall;
			stall_left = out_stall ? $urandom_range(0, 11) : $urandom_range(0, 5);
		end
	end

	// Check each accepted result item against the oldest expected sum
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected path_sum %0d", path_sum));
			end else begin
				want_sum = expected_sums.pop_front();
				if (path_sum !== want_sum)
					report_mismatch($sformatf("path_sum %0d, expected %0d",
						path_sum, want_sum));
			end
		end
	end

	initial begin
		int unsigned n;
		int unsigned grids;
		int unsigned cells;
		int unsigned mode;
		int unsigned rand_cells;

		// Directed cases: single-cell grids, zero size, a 2x2 grid, max weights,
		// a grid dropped by a size write, and a 3x3 grid
		dir_table = '{
			'{1'b1, 8'd1, 16'd0,     1'b1, 24'd0},
			'{1'b0, 8'd1, 16'hFFFF,  1'b1, 24'd65535},
			'{1'b0, 8'd1, 16'h5A5A,  1'b1, 24'h005A5A},
			'{1'b1, 8'd0, 16'd12345, 1'b1, 24'd12345},
			'{1'b0, 8'd0, 16'd0,     1'b1, 24'd0},
			'{1'b1, 8'd2, 16'd1,     1'b0, 24'd0},
			'{1'b0, 8'd2, 16'd10,    1'b0, 24'd0},
			'{1'b0, 8'd2, 16'd100,   1'b0, 24'd0},
			'{1'b0, 8'd2, 16'd1000,  1'b1, 24'd1011},
			'{1'b0, 8'd2, 16'hFFFF,  1'b0, 24'd0},
			'{1'b0, 8'd2, 16'hFFFF,  1'b0, 24'd0},
			'{1'b0, 8'd2, 16'hFFFF,  1'b0, 24'd0},
			'{1'b0, 8'd2, 16'hFFFF,  1'b1, 24'd196605},
			'{1'b1, 8'd3, 16'd5,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd4,     1'b0, 24'd0},
			'{1'b1, 8'd3, 16'd1,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd2,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd3,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd4,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd5,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd6,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd7,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd8,     1'b0, 24'd0},
			'{1'b0, 8'd3, 16'd9,     1'b0, 24'd0}
		};

		// Predictor reset state
		for (int k = 0; k < MAX_SIZE_DEF; k++) best_above[k] = '0;
		best_left = '0;
		cur_row = 0;
		cur_col = 0;
		size_reg = CFG_W'(GRID_SIZE_RESET);
		errors = 0;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		burst_left = 0;
		stall_left = 0;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Part of a grid at the size left by reset, past its first row; dropped below
		for (int k = 0; k < RESET_CELLS; k++)
			send_cell(rand_weight(3));

		// Walk the directed table
		for (int k = 0; k < DIR_N; k++) begin
			if (dir_table[k].new_size) begin
				settle();
				write_size(dir_table[k].size);
			end
			push_cell(dir_table[k].weight, dir_table[k].has_sum, dir_table[k].sum);
			pace();
		end

		// Random phases: mostly small grids, whole grids with random content,
		// some left unfinished and dropped by the next size write
		rand_cells = 0;
		while (rand_cells < RAND_ITEMS) begin
			settle();
			mode = $urandom_range(0, 19);
			if (mode < 16) n = $urandom_range(0, 6);
			else n = $urandom_range(7, 12);
			write_size(CFG_W'(n));
			if (n == 0) n = 1;
			gaps_on = ($urandom_range(0, 4) != 0);
			stall_on = ($urandom_range(0, 4) != 0);
			mode = $urandom_range(0, 5);
			grids = $urandom_range(1, 3);
			cells = grids * n * n;
			if ($urandom_range(0, 3) == 0 && n > 1) cells += $urandom_range(1, n * n - 1);
			if (cells > RAND_ITEMS - rand_cells) cells = RAND_ITEMS - rand_cells;
			for (int k = 0; k < cells; k++) send_cell(rand_weight(mode));
			rand_cells += cells;
		end

		// Oversized setting saturates to the largest grid; run past its first row
		settle();
		write_size('1);
		gaps_on = 1'b1;
		stall_on = 1'b1;
		for (int k = 0; k < BIG_CELLS; k++) send_cell(rand_weight(3));

		// Drop that grid and check a single-cell grid right after it
		settle();
		write_size(CFG_W'(1));
		send_cell('1);

		in_valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
